FILE: rtl/core/lru_pkg.sv
package lru_pkg;

  localparam int unsigned TableEntries = 256;
  localparam int unsigned ProbeSlots = 4;
  localparam int unsigned LookupSlots = 2;
  localparam int unsigned MaxKeyBytes = 8;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned PtrW = IdxW + 1;
  localparam logic [PtrW-1:0] NilPtr = PtrW'(TableEntries);

  localparam logic [1:0] OpPut = 2'd0;
  localparam logic [1:0] OpIncr = 2'd1;
  localparam logic [1:0] OpLookup = 2'd2;
  localparam logic [1:0] OpClear = 2'd3;

  localparam logic [1:0] StHit = 2'd0;
  localparam logic [1:0] StFree = 2'd1;
  localparam logic [1:0] StEvict = 2'd2;
  localparam logic [1:0] StMiss = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key;
    logic [3:0]  len;
    logic [63:0] hash;
    logic [30:0] freq;
    logic [31:0] level;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  slot;
    logic [31:0] freq;
    logic [31:0] level;
    logic [31:0] savings;
  } rsp_t;

  typedef enum logic [3:0] {
    CmdNone,
    CmdLoad,
    CmdRead,
    CmdCheck,
    CmdClear,
    CmdHitWrite,
    CmdInsert,
    CmdUnlinkA,
    CmdUnlinkB,
    CmdPushA,
    CmdPushB,
    CmdRespMiss,
    CmdRespClear,
    CmdSetEvict
  } cmd_e;

  typedef struct packed {
    cmd_e            cmd;
    logic [IdxW-1:0] probe;
  } ctl_t;

  typedef struct packed {
    logic match;
    logic free;
    logic tail_nil;
    logic slot_valid;
  } sts_t;

  function automatic logic [63:0] key_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int b = 0; b < 8; b++) begin
      if ((b < MaxKeyBytes) && (4'(b) < len)) m[b*8 +: 8] = 8'hff;
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/lru_hash_frequency_table.sv
// Channel   Direction  tdata fields (low bit up)
// s_axis    in         opcode, key_bytes, key_size, key_hash, new_frequency, level_tag
// m_axis    out        status, slot_index, frequency_out, level_out, savings_added
// Each probe reads a slot, checks it and evaluates the match. A put or increment hit
// relinks the entry at the head of the LRU list (unlink, then push) before tvalid is
// raised; a lookup hit returns the entry without relinking. An increment probes the
// whole table before it misses; a miss by put or increment then searches free slots
// and evicts the LRU tail if none is free. Clear empties the table. Reset empties the
// table at once. A stalled result holds the block, which accepts a new word only from idle.
module lru_hash_frequency_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [199:0] s_axis_tdata, // opcode, key_bytes, key_size, key_hash,
                                     // new_frequency, level_tag
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [111:0] m_axis_tdata  // status, slot_index, frequency_out, level_out,
                                     // savings_added
);
  import lru_pkg::*;

  req_t req;
  ctl_t ctl;
  sts_t sts;
  rsp_t rsp;
  logic fire;

  assign req.opcode = s_axis_tdata[1:0];
  assign req.key = s_axis_tdata[65:2];
  assign req.len = s_axis_tdata[69:66];
  assign req.hash = s_axis_tdata[133:70];
  assign req.freq = s_axis_tdata[164:134];
  assign req.level = s_axis_tdata[196:165];
  assign fire = s_axis_tvalid && s_axis_tready;

  lru_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(fire), .opcode_i(req.opcode), .sts_i(sts),
    .out_ready_i(m_axis_tready), .ctl_o(ctl), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid)
  );

  lru_datapath u_dp (
    .clk_i, .rst_ni, .req_i(req), .ctl_i(ctl), .sts_o(sts), .rsp_o(rsp)
  );

  assign m_axis_tdata = {6'b000000, rsp.savings, rsp.level, rsp.freq, rsp.slot, rsp.status};

`ifndef SYNTHESIS
  a_no_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("ready while result pending");
  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready) else $error("no return to idle");
`endif

endmodule

FILE: rtl/core/lru_datapath.sv
module lru_datapath (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  lru_pkg::req_t req_i,
  input  lru_pkg::ctl_t ctl_i,
  output lru_pkg::sts_t sts_o,
  output lru_pkg::rsp_t rsp_o
);
  import lru_pkg::*;

  logic [TableEntries-1:0] valid_q;
  logic [63:0] hash_m [TableEntries];
  logic [63:0] key_m [TableEntries];
  logic [3:0]  len_m [TableEntries];
  logic [31:0] cnt_m [TableEntries];
  logic [31:0] lvl_m [TableEntries];
  logic [PtrW-1:0] prev_m [TableEntries];
  logic [PtrW-1:0] next_m [TableEntries];
  logic [PtrW-1:0] head_q, tail_q;

  req_t req_q;
  req_t req_d;
  logic [IdxW-1:0] slot_q;
  logic [63:0] rh_q, rk_q;
  logic [3:0]  rl_q;
  logic [31:0] rc_q;
  logic [PtrW-1:0] rp_q, rn_q;
  logic [31:0] lm_q;
  rsp_t rsp_q;
  logic [31:0] newf;
  logic [31:0] lm_d;

  assign newf = (req_q.opcode == OpIncr) ? rc_q + 32'd1 : {1'b0, req_q.freq};
  assign lm_d = {28'd0, rl_q} - 32'd1;

  always_comb begin
    req_d = req_i;
    req_d.key = req_i.key & key_mask(req_i.len);
  end

  always_comb begin
    sts_o.slot_valid = valid_q[slot_q];
    sts_o.free = !valid_q[slot_q];
    sts_o.match = valid_q[slot_q] && rh_q == req_q.hash && rl_q == req_q.len
                  && rk_q == req_q.key;
    sts_o.tail_nil = tail_q == NilPtr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      head_q <= NilPtr;
      tail_q <= NilPtr;
    end else begin
      case (ctl_i.cmd)
        CmdClear: begin
          valid_q <= '0;
          head_q <= NilPtr;
          tail_q <= NilPtr;
        end
        CmdUnlinkA: begin
          if (valid_q[slot_q]) begin
            if (rp_q == NilPtr) head_q <= rn_q;
            if (rn_q == NilPtr) tail_q <= rp_q;
          end
        end
        CmdPushB: begin
          if (head_q == NilPtr) tail_q <= {1'b0, slot_q};
          head_q <= {1'b0, slot_q};
          valid_q[slot_q] <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (ctl_i.cmd)
      CmdLoad: begin
        req_q <= req_d;
      end
      CmdRead: begin
        slot_q <= req_q.hash[IdxW-1:0] + ctl_i.probe;
      end
      CmdSetEvict: slot_q <= tail_q[IdxW-1:0];
      CmdCheck: begin
        rh_q <= hash_m[slot_q];
        rk_q <= key_m[slot_q];
        rl_q <= len_m[slot_q];
        rc_q <= cnt_m[slot_q];
        rp_q <= prev_m[slot_q];
        rn_q <= next_m[slot_q];
      end
      CmdHitWrite: begin
        cnt_m[slot_q] <= newf;
        lvl_m[slot_q] <= req_q.level;
        lm_q <= lm_d * lm_d;
        rc_q <= newf;
      end
      CmdInsert: begin
        hash_m[slot_q] <= req_q.hash;
        key_m[slot_q] <= req_q.key;
        len_m[slot_q] <= req_q.len;
        cnt_m[slot_q] <= (req_q.opcode == OpIncr) ? 32'd1 : {1'b0, req_q.freq};
        lvl_m[slot_q] <= req_q.level;
        rc_q <= (req_q.opcode == OpIncr) ? 32'd1 : {1'b0, req_q.freq};
        lm_q <= '0;
      end
      CmdUnlinkA: begin
        if (valid_q[slot_q]) begin
          if (rp_q != NilPtr) next_m[rp_q[IdxW-1:0]] <= rn_q;
        end
      end
      CmdUnlinkB: begin
        if (valid_q[slot_q] && rn_q != NilPtr) prev_m[rn_q[IdxW-1:0]] <= rp_q;
      end
      CmdPushA: begin
        next_m[slot_q] <= head_q;
        prev_m[slot_q] <= NilPtr;
      end
      CmdPushB: begin
        if (head_q != NilPtr) prev_m[head_q[IdxW-1:0]] <= {1'b0, slot_q};
        rsp_q.slot <= 8'(slot_q);
        rsp_q.freq <= rc_q;
        rsp_q.level <= req_q.level;
        rsp_q.savings <= (req_q.opcode == OpIncr && rsp_q.status == StHit) ?
                         lm_q * (rc_q - 32'd1) : 32'd0;
      end
      CmdRespMiss: rsp_q <= '{status: StMiss, default: '0};
      CmdRespClear: rsp_q <= '{status: StHit, default: '0};
      default: ;
    endcase
    if (ctl_i.cmd == CmdHitWrite) rsp_q.status <= StHit;
    if (ctl_i.cmd == CmdInsert) rsp_q.status <= valid_q[slot_q] ? StEvict : StFree;
    if (ctl_i.cmd == CmdCheck && req_q.opcode == OpLookup) begin
      rsp_q.slot <= 8'(slot_q);
      rsp_q.freq <= cnt_m[slot_q];
      rsp_q.level <= lvl_m[slot_q];
      rsp_q.savings <= '0;
      rsp_q.status <= StHit;
    end
  end

  assign rsp_o = rsp_q;

endmodule

FILE: rtl/core/lru_ctrl.sv
module lru_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_fire_i,
  input  logic [1:0]    opcode_i,
  input  lru_pkg::sts_t sts_i,
  input  logic          out_ready_i,
  output lru_pkg::ctl_t ctl_o,
  output logic          in_ready_o,
  output logic          out_valid_o
);
  import lru_pkg::*;

  typedef enum logic [3:0] {
    SIdle, SRead, SCheck, SEval, SHit, SFind, SFindChk, SFindEval, SEvict,
    SEvChk, SIns, SUnA, SUnB, SPushA, SPushB, SOut
  } state_e;

  state_e state_q;
  logic [1:0] op_q;
  logic [IdxW:0] cnt_q;
  logic [IdxW:0] lim;
  logic more;
  logic find_more;

  assign lim = (op_q == OpIncr) ? (IdxW+1)'(TableEntries) :
               (op_q == OpLookup) ? (IdxW+1)'(LookupSlots) : (IdxW+1)'(ProbeSlots);
  assign more = (cnt_q + 1'b1) < lim;
  assign find_more = (cnt_q + 1'b1) < (IdxW+1)'(ProbeSlots);
  assign in_ready_o = state_q == SIdle;
  assign out_valid_o = state_q == SOut;

  always_comb begin
    ctl_o = '{cmd: CmdNone, probe: cnt_q[IdxW-1:0]};
    case (state_q)
      SIdle: begin
        if (in_fire_i) begin
          if (opcode_i == OpClear) ctl_o.cmd = CmdClear;
          else ctl_o.cmd = CmdLoad;
        end
      end
      SRead, SFind: ctl_o.cmd = CmdRead;
      SCheck, SEvChk: ctl_o.cmd = CmdCheck;
      SEval: begin
        if (op_q == OpClear) ctl_o.cmd = CmdRespClear;
        else if (sts_i.match) begin
          if (op_q != OpLookup) ctl_o.cmd = CmdHitWrite;
        end else if (!more && op_q == OpLookup) ctl_o.cmd = CmdRespMiss;
      end
      SFindEval: begin
        if (sts_i.free) ctl_o.cmd = CmdInsert;
        else if (find_more) ctl_o.cmd = CmdNone;
        else if (sts_i.tail_nil) ctl_o.cmd = CmdRespMiss;
        else ctl_o.cmd = CmdSetEvict;
      end
      SIns: ctl_o.cmd = CmdInsert;
      SUnA: ctl_o.cmd = CmdUnlinkA;
      SUnB: ctl_o.cmd = CmdUnlinkB;
      SPushA: ctl_o.cmd = CmdPushA;
      SPushB: ctl_o.cmd = CmdPushB;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      op_q <= OpPut;
      cnt_q <= '0;
    end else begin
      case (state_q)
        SIdle: if (in_fire_i) begin
          op_q <= opcode_i;
          cnt_q <= '0;
          if (opcode_i == OpClear) state_q <= SEval;
          else state_q <= SRead;
        end
        SRead: state_q <= SCheck;
        SCheck: state_q <= SEval;
        SEval: begin
          if (op_q == OpClear) state_q <= SOut;
          else if (sts_i.match) begin
            if (op_q == OpLookup) state_q <= SOut;
            else state_q <= SUnA;
          end else if (more) begin
            cnt_q <= cnt_q + 1'b1;
            state_q <= SRead;
          end else if (op_q == OpLookup) begin
            state_q <= SOut;
          end else begin
            cnt_q <= '0;
            state_q <= SFind;
          end
        end
        SFind: state_q <= SFindChk;
        SFindChk: state_q <= SFindEval;
        SFindEval: begin
          if (sts_i.free) state_q <= SPushA;
          else if (find_more) begin
            cnt_q <= cnt_q + 1'b1;
            state_q <= SFind;
          end else if (sts_i.tail_nil) state_q <= SOut;
          else state_q <= SEvChk;
        end
        SEvChk: state_q <= SIns;
        SIns: state_q <= SUnA;
        SUnA: state_q <= SUnB;
        SUnB: state_q <= SPushA;
        SPushA: state_q <= SPushB;
        SPushB: state_q <= SOut;
        SOut: if (out_ready_i) state_q <= SIdle;
        default: state_q <= SIdle;
      endcase
    end
  end

endmodule
